### rtl/core/iets_pkg.sv
// ----------------------------------------------------------------------------
// iets_pkg
// shared types, codes and masks for the i2c eeprom transfer sequencer
// ----------------------------------------------------------------------------
package iets_pkg;

  localparam int          COUNT_WIDTH_DEF = 16;
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'd160;

  // item kind
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  // operation
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // read/write bit of the control byte
  localparam logic [7:0] RW_READ_BIT = 8'h01;

  // transfer status
  localparam logic [1:0] RS_OK          = 2'd0;
  localparam logic [1:0] RS_DEV_W_NACK  = 2'd1;
  localparam logic [1:0] RS_DATA_NACK   = 2'd2;
  localparam logic [1:0] RS_DEV_R_NACK  = 2'd3;

  // control set mask bits
  localparam logic [3:0] SET_NONE  = 4'h0;
  localparam logic [3:0] SET_ACK   = 4'h1;
  localparam logic [3:0] SET_STOP  = 4'h2;
  localparam logic [3:0] SET_START = 4'h4;
  localparam logic [3:0] SET_EN    = 4'h8;

  // control clear mask bits
  localparam logic [4:0] CLR_NONE  = 5'h00;
  localparam logic [4:0] CLR_ACK   = 5'h01;
  localparam logic [4:0] CLR_IRQ   = 5'h02;
  localparam logic [4:0] CLR_STOP  = 5'h04;
  localparam logic [4:0] CLR_START = 5'h08;
  localparam logic [4:0] CLR_EN    = 5'h10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HIGH,
    PH_ADDR_LOW,
    PH_WRITE,
    PH_REP_START,
    PH_READ
  } phase_t;

  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_REP_START  = 4'd1,
    ST_SLAW_ACK   = 4'd2,
    ST_SLAW_NACK  = 4'd3,
    ST_DW_ACK     = 4'd4,
    ST_DW_NACK    = 4'd5,
    ST_LOST       = 4'd6,
    ST_SLAR_ACK   = 4'd7,
    ST_SLAR_NACK  = 4'd8,
    ST_DR_ACK     = 4'd9,
    ST_DR_NACK    = 4'd10,
    ST_NOINFO     = 4'd11
  } bus_st_t;

  typedef struct packed {
    logic        func;
    logic        operation;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic [3:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_out;
    logic       tx_consumed;
    logic       rx_valid;
    logic [7:0] rx_out;
    logic [3:0] ctl_set;
    logic [4:0] ctl_clear;
    logic       busy_res;
    logic [1:0] result_status;
  } res_t;

endpackage

### rtl/core/iets_in_reg.sv
// ----------------------------------------------------------------------------
// iets_in_reg
// input register stage, holds one transaction until the decode stage takes it
// ----------------------------------------------------------------------------
module iets_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iets_pkg::item_t item_in,
  input  logic          ds_ready,
  output logic          take,
  output iets_pkg::item_t item_q
);
  import iets_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign take     = vld_r && ds_ready;
  assign in_ready = !vld_r || ds_ready;
  assign item_q   = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_in;
    end
  end

endmodule

### rtl/core/iets_step.sv
// ----------------------------------------------------------------------------
// iets_step
// transfer state and per-transaction decode of starts and bus events
// ----------------------------------------------------------------------------
module iets_step #(
  parameter int COUNT_WIDTH = iets_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  iets_pkg::item_t item,
  input  logic [7:0]      dev_addr,
  output iets_pkg::res_t  res
);
  import iets_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic                   op_is_read_r, op_is_read_nxt;
  logic [15:0]            target_r, target_nxt;
  logic [COUNT_WIDTH-1:0] remaining_r, remaining_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic                   rem_gt1;
  bus_st_t                st;

  assign st      = bus_st_t'(item.bus_status);
  // count down saturating at zero
  assign rem_dec = (remaining_r != '0) ? remaining_r - COUNT_WIDTH'(1) : remaining_r;
  // still bytes left after this count down
  assign rem_gt1 = |remaining_r[COUNT_WIDTH-1:1];

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    op_is_read_nxt = op_is_read_r;
    target_nxt     = target_r;
    remaining_nxt  = remaining_r;
    status_nxt     = status_r;
    if (item.func == FUNC_START) begin
      if (phase_r == PH_IDLE) begin
        op_is_read_nxt = item.operation;
        target_nxt     = item.mem_address;
        remaining_nxt  = COUNT_WIDTH'(item.byte_count);
        status_nxt     = RS_OK;
        phase_nxt      = PH_ADDR_HIGH;
      end
    end else if (st != ST_NOINFO && phase_r != PH_IDLE) begin
      unique case (st)
        ST_START:     phase_nxt = PH_ADDR_HIGH;
        ST_REP_START: phase_nxt = PH_READ;
        ST_SLAW_ACK:  phase_nxt = PH_ADDR_LOW;
        ST_SLAW_NACK: begin
          status_nxt = RS_DEV_W_NACK;
          phase_nxt  = PH_IDLE;
        end
        ST_DW_ACK: begin
          unique case (phase_r)
            PH_ADDR_LOW:  phase_nxt = (op_is_read_r == OP_READ) ? PH_REP_START : PH_WRITE;
            PH_REP_START: phase_nxt = PH_READ;
            PH_WRITE: begin
              if (remaining_r != '0) begin
                remaining_nxt = rem_dec;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        ST_DW_NACK: begin
          status_nxt = RS_DATA_NACK;
          phase_nxt  = PH_IDLE;
        end
        ST_LOST:      phase_nxt = PH_IDLE;
        ST_SLAR_ACK:  remaining_nxt = rem_dec;
        ST_SLAR_NACK: begin
          status_nxt = RS_DEV_R_NACK;
          phase_nxt  = PH_IDLE;
        end
        ST_DR_ACK:    remaining_nxt = rem_dec;
        ST_DR_NACK: begin
          remaining_nxt = rem_dec;
          phase_nxt     = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res               = '0;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.result_status = status_nxt;
    if (item.func == FUNC_START) begin
      if (phase_r == PH_IDLE) begin
        res.ctl_set = SET_START;
      end
    end else if (st == ST_NOINFO) begin
      res.ctl_set   = SET_EN;
      res.ctl_clear = CLR_EN;
    end else if (phase_r != PH_IDLE) begin
      unique case (st)
        ST_START: begin
          res.tx_valid  = 1'b1;
          res.tx_out    = dev_addr;
          res.ctl_clear = CLR_IRQ | CLR_START;
        end
        ST_REP_START: begin
          res.tx_valid  = 1'b1;
          res.tx_out    = dev_addr | RW_READ_BIT;
          res.ctl_clear = CLR_IRQ | CLR_START;
        end
        ST_SLAW_ACK: begin
          res.tx_valid  = 1'b1;
          res.tx_out    = target_r[15:8];
          res.ctl_clear = CLR_IRQ | CLR_START | CLR_STOP;
        end
        ST_SLAW_NACK, ST_SLAR_NACK: begin
          res.ctl_clear = CLR_IRQ | CLR_START;
          res.ctl_set   = SET_STOP;
        end
        ST_DW_ACK: begin
          unique case (phase_r)
            PH_ADDR_LOW: begin
              res.tx_valid  = 1'b1;
              res.tx_out    = target_r[7:0];
              res.ctl_clear = CLR_IRQ;
            end
            PH_REP_START: begin
              res.ctl_set   = SET_START;
              res.ctl_clear = CLR_IRQ;
            end
            PH_WRITE: begin
              res.ctl_clear = CLR_IRQ;
              if (remaining_r != '0) begin
                res.tx_valid    = 1'b1;
                res.tx_out      = item.tx_byte;
                res.tx_consumed = 1'b1;
                res.ctl_set     = SET_ACK;
              end else begin
                res.ctl_set = SET_STOP;
              end
            end
            default: ;
          endcase
        end
        ST_DW_NACK: begin
          res.ctl_clear = CLR_IRQ;
          res.ctl_set   = SET_STOP;
        end
        ST_LOST: res.ctl_clear = CLR_IRQ | CLR_START | CLR_STOP;
        ST_SLAR_ACK: begin
          if (rem_gt1) begin
            res.ctl_clear = CLR_IRQ | CLR_START;
            res.ctl_set   = SET_ACK;
          end else begin
            res.ctl_clear = CLR_IRQ | CLR_START | CLR_ACK;
          end
        end
        ST_DR_ACK: begin
          res.rx_valid = 1'b1;
          res.rx_out   = item.rx_byte;
          if (rem_gt1) begin
            res.ctl_clear = CLR_IRQ;
            res.ctl_set   = SET_ACK;
          end else begin
            res.ctl_clear = CLR_IRQ | CLR_ACK;
          end
        end
        ST_DR_NACK: begin
          res.rx_valid  = 1'b1;
          res.rx_out    = item.rx_byte;
          res.ctl_clear = CLR_IRQ;
          res.ctl_set   = SET_STOP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      op_is_read_r <= 1'b0;
      target_r     <= '0;
      remaining_r  <= '0;
      status_r     <= RS_OK;
    end else if (take) begin
      phase_r      <= phase_nxt;
      op_is_read_r <= op_is_read_nxt;
      target_r     <= target_nxt;
      remaining_r  <= remaining_nxt;
      status_r     <= status_nxt;
    end
  end

endmodule

### rtl/core/i2c_eeprom_transfer_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer_top
// sequences one i2c eeprom write or random read on a byte-level i2c master
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, in_func .. in_tx_byte | to block
//  out     | out_valid/out_ready, out_tx_valid ..     | from block
//  cfg     | cfg_valid/cfg_ready, cfg_data            | to block
//
//  one transaction per cycle while the out channel is not stalled; out_valid
//  rises once an accepted transaction has passed the input register and then
//  the decode into the result register
//  the decode is a small case on the bus status and the phase register
//  reset: synchronous active low, phase idle, device address 160
//  a stalled out channel holds the result and back-pressures in through
//  the input register; cfg_ready is always high
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer_top #(
  parameter int COUNT_WIDTH = iets_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // start / bus event transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic        in_operation,
  input  logic [15:0] in_mem_address,
  input  logic [15:0] in_byte_count,
  input  logic [3:0]  in_bus_status,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_tx_byte,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_out,
  output logic        out_tx_consumed,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_out,
  output logic [3:0]  out_ctl_set,
  output logic [4:0]  out_ctl_clear,
  output logic        out_busy_res,
  output logic [1:0]  out_result_status,
  // device address register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import iets_pkg::*;

  item_t      item_in;
  item_t      item_q;
  res_t       res;
  res_t       res_r;
  logic       take;
  logic       ds_ready;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic [7:0] dev_addr_r;

  // device address register; the host must write it only while nothing is in flight, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  assign item_in = '{func:        in_func,
                     operation:   in_operation,
                     mem_address: in_mem_address,
                     byte_count:  in_byte_count,
                     bus_status:  in_bus_status,
                     rx_byte:     in_rx_byte,
                     tx_byte:     in_tx_byte};

  // result register free or being emptied this cycle
  assign ds_ready = !out_vld_r || out_ready;

  iets_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .ds_ready (ds_ready),
    .take     (take),
    .item_q   (item_q)
  );

  // state advances exactly when a transaction moves into the result register
  iets_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (item_q),
    .dev_addr (dev_addr_r),
    .res      (res)
  );

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_tx_valid      = res_r.tx_valid;
  assign out_tx_out        = res_r.tx_out;
  assign out_tx_consumed   = res_r.tx_consumed;
  assign out_rx_valid      = res_r.rx_valid;
  assign out_rx_out        = res_r.rx_out;
  assign out_ctl_set       = res_r.ctl_set;
  assign out_ctl_clear     = res_r.ctl_clear;
  assign out_busy_res      = res_r.busy_res;
  assign out_result_status = res_r.result_status;

  // a taken write byte is always loaded and acknowledged
  a_consume_loads : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_consumed |-> out_tx_valid && out_ctl_set == SET_ACK)
    else $error("write byte taken without load");

  // an error status only appears once the transfer has ended
  a_busy_status_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> out_result_status == RS_OK)
    else $error("error status while transfer still busy");

  // a mid-transfer received byte either acks or clears ack, never both
  a_rx_ack : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid && out_busy_res |->
      (out_ctl_set == SET_ACK && out_ctl_clear == CLR_IRQ) ||
      (out_ctl_set == SET_NONE && out_ctl_clear == (CLR_IRQ | CLR_ACK)))
    else $error("inconsistent ack control on received byte");

  // the input stage only hands on a transaction when the result side can take it
  a_take_ready : assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("result lost after decode");

endmodule

### bench/i2c_eeprom_transfer_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer_top_tb
// self-checking bench for the i2c eeprom transfer sequencer: directed corner
// cases, then well-formed write and read transfers with random content,
// faults and noise, with random idling on both channels, a long output stall
// and several device address settings; every result is checked field by
// field against a predictor kept in step at each accepted transaction
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer_top_tb;
  import iets_pkg::*;

  localparam int LIMIT_CYCLES     = 400000;
  localparam int MAX_BURST        = 24;   // data events per transfer before forcing a fault
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int MAX_PRINTS       = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic        in_operation;
  logic [15:0] in_mem_address;
  logic [15:0] in_byte_count;
  logic [3:0]  in_bus_status;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_tx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_out;
  logic        out_tx_consumed;
  logic        out_rx_valid;
  logic [7:0]  out_rx_out;
  logic [3:0]  out_ctl_set;
  logic [4:0]  out_ctl_clear;
  logic        out_busy_res;
  logic [1:0]  out_result_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // predictor state, updated at each accepted transaction
  phase_t      sq_phase;
  logic        sq_read;
  logic [15:0] sq_addr;
  logic [15:0] sq_left;
  logic [1:0]  sq_status;
  logic [7:0]  sq_dev;

  res_t pending_results[$];
  int   err_count   = 0;
  int   items_sent  = 0;
  int   cycle_count = 0;
  int   stall_req   = 0;   // bumped to ask the sink for one long hold-off
  bit   idle_en     = 1'b1;

  i2c_eeprom_transfer_sequencer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_operation      (in_operation),
    .in_mem_address    (in_mem_address),
    .in_byte_count     (in_byte_count),
    .in_bus_status     (in_bus_status),
    .in_rx_byte        (in_rx_byte),
    .in_tx_byte        (in_tx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_valid      (out_tx_valid),
    .out_tx_out        (out_tx_out),
    .out_tx_consumed   (out_tx_consumed),
    .out_rx_valid      (out_rx_valid),
    .out_rx_out        (out_rx_out),
    .out_ctl_set       (out_ctl_set),
    .out_ctl_clear     (out_ctl_clear),
    .out_busy_res      (out_busy_res),
    .out_result_status (out_result_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // predictor: works out the result of one transaction and advances state
  // ------------------------------------------------------------------------
  function automatic res_t sequencer_next(input item_t it);
    res_t r;
    r = '0;
    if (it.func == FUNC_START) begin
      // a start while a transfer runs is dropped without action
      if (sq_phase == PH_IDLE) begin
        sq_read   = it.operation;
        sq_addr   = it.mem_address;
        sq_left   = it.byte_count;
        sq_status = RS_OK;
        sq_phase  = PH_ADDR_HIGH;
        r.ctl_set = SET_START;
      end
    end else if (it.bus_status == ST_NOINFO) begin
      // re-enable the controller in any phase, idle included
      r.ctl_clear = CLR_EN;
      r.ctl_set   = SET_EN;
    end else if (sq_phase != PH_IDLE) begin
      case (it.bus_status)
        ST_START: begin
          r.tx_valid  = 1'b1;
          r.tx_out    = sq_dev;
          r.ctl_clear = CLR_IRQ | CLR_START;
          sq_phase    = PH_ADDR_HIGH;
        end
        ST_REP_START: begin
          r.tx_valid  = 1'b1;
          r.tx_out    = sq_dev | RW_READ_BIT;
          r.ctl_clear = CLR_IRQ | CLR_START;
          sq_phase    = PH_READ;
        end
        ST_SLAW_ACK: begin
          r.tx_valid  = 1'b1;
          r.tx_out    = sq_addr[15:8];
          r.ctl_clear = CLR_IRQ | CLR_START | CLR_STOP;
          sq_phase    = PH_ADDR_LOW;
        end
        ST_SLAW_NACK: begin
          r.ctl_clear = CLR_IRQ | CLR_START;
          r.ctl_set   = SET_STOP;
          sq_status   = RS_DEV_W_NACK;
          sq_phase    = PH_IDLE;
        end
        ST_DW_ACK: begin
          if (sq_phase == PH_ADDR_LOW) begin
            r.tx_valid  = 1'b1;
            r.tx_out    = sq_addr[7:0];
            r.ctl_clear = CLR_IRQ;
            sq_phase    = sq_read ? PH_REP_START : PH_WRITE;
          end else if (sq_phase == PH_REP_START) begin
            r.ctl_set   = SET_START;
            r.ctl_clear = CLR_IRQ;
            sq_phase    = PH_READ;
          end else if (sq_phase == PH_WRITE) begin
            if (sq_left != '0) begin
              r.tx_valid    = 1'b1;
              r.tx_out      = it.tx_byte;
              r.tx_consumed = 1'b1;
              r.ctl_set     = SET_ACK;
              sq_left       = sq_left - 1'b1;
            end else begin
              // nothing left to write, zero-byte writes included
              r.ctl_set = SET_STOP;
              sq_phase  = PH_IDLE;
            end
            r.ctl_clear = CLR_IRQ;
          end
        end
        ST_DW_NACK: begin
          r.ctl_clear = CLR_IRQ;
          r.ctl_set   = SET_STOP;
          sq_status   = RS_DATA_NACK;
          sq_phase    = PH_IDLE;
        end
        ST_LOST: begin
          r.ctl_clear = CLR_IRQ | CLR_START | CLR_STOP;
          sq_phase    = PH_IDLE;
        end
        ST_SLAR_ACK: begin
          if (sq_left != '0) sq_left = sq_left - 1'b1;
          r.ctl_clear = CLR_IRQ | CLR_START;
          if (sq_left != '0) r.ctl_set = SET_ACK;
          else r.ctl_clear = r.ctl_clear | CLR_ACK;
        end
        ST_SLAR_NACK: begin
          r.ctl_clear = CLR_IRQ | CLR_START;
          r.ctl_set   = SET_STOP;
          sq_status   = RS_DEV_R_NACK;
          sq_phase    = PH_IDLE;
        end
        ST_DR_ACK: begin
          r.rx_valid  = 1'b1;
          r.rx_out    = it.rx_byte;
          if (sq_left != '0) sq_left = sq_left - 1'b1;
          r.ctl_clear = CLR_IRQ;
          if (sq_left != '0) r.ctl_set = SET_ACK;
          else r.ctl_clear = r.ctl_clear | CLR_ACK;
        end
        ST_DR_NACK: begin
          r.rx_valid  = 1'b1;
          r.rx_out    = it.rx_byte;
          if (sq_left != '0) sq_left = sq_left - 1'b1;
          r.ctl_clear = CLR_IRQ;
          r.ctl_set   = SET_STOP;
          sq_phase    = PH_IDLE;
        end
        default: ;  // unused codes do nothing
      endcase
    end
    r.busy_res      = (sq_phase != PH_IDLE);
    r.result_status = sq_status;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // mismatch reporting and result checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_tx_valid, out_tx_out, out_tx_consumed, out_rx_valid, out_rx_out,
             out_ctl_set, out_ctl_clear, out_busy_res, out_result_status};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.tx_valid !== want.tx_valid)
          report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
        if (got.tx_out !== want.tx_out)
          report_mismatch("tx_out", 32'(got.tx_out), 32'(want.tx_out));
        if (got.tx_consumed !== want.tx_consumed)
          report_mismatch("tx_consumed", 32'(got.tx_consumed), 32'(want.tx_consumed));
        if (got.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", 32'(got.rx_valid), 32'(want.rx_valid));
        if (got.rx_out !== want.rx_out)
          report_mismatch("rx_out", 32'(got.rx_out), 32'(want.rx_out));
        if (got.ctl_set !== want.ctl_set)
          report_mismatch("ctl_set", 32'(got.ctl_set), 32'(want.ctl_set));
        if (got.ctl_clear !== want.ctl_clear)
          report_mismatch("ctl_clear", 32'(got.ctl_clear), 32'(want.ctl_clear));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.result_status !== want.result_status)
          report_mismatch("result_status", 32'(got.result_status),
                          32'(want.result_status));
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk);
      if (seen != stall_req) begin
        seen      = stall_req;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 7);
      end
    end
  end

  // ------------------------------------------------------------------------
  // transaction builders and drivers
  // ------------------------------------------------------------------------
  function automatic item_t random_item();
    item_t it;
    it.func        = 1'($urandom_range(0, 1));
    it.operation   = 1'($urandom_range(0, 1));
    it.mem_address = 16'($urandom);
    it.byte_count  = 16'($urandom);
    it.bus_status  = 4'($urandom_range(0, 15));
    it.rx_byte     = 8'($urandom_range(0, 255));
    it.tx_byte     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // unused fields keep random junk so that the block has to ignore them
  function automatic item_t start_of(input logic op, input logic [15:0] addr,
                                     input logic [15:0] cnt);
    item_t it;
    it             = random_item();
    it.func        = FUNC_START;
    it.operation   = op;
    it.mem_address = addr;
    it.byte_count  = cnt;
    return it;
  endfunction

  function automatic item_t event_of(input logic [3:0] st);
    item_t it;
    it            = random_item();
    it.func       = FUNC_EVENT;
    it.bus_status = st;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (idle_en && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_operation   <= it.operation;
    in_mem_address <= it.mem_address;
    in_byte_count  <= it.byte_count;
    in_bus_status  <= it.bus_status;
    in_rx_byte     <= it.rx_byte;
    in_tx_byte     <= it.tx_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(sequencer_next(it));
    items_sent++;
  endtask

  // a stray no-info now and then, as the controller may raise it anywhere
  task automatic send_event(input logic [3:0] st);
    if ($urandom_range(0, 29) == 0) send_item(event_of(ST_NOINFO));
    send_item(event_of(st));
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_device_address(input logic [7:0] value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sq_dev = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pick_fault();
    case ($urandom_range(0, 5))
      0: return ST_SLAW_NACK;
      1: return ST_DW_NACK;
      2: return ST_LOST;
      3: return ST_SLAR_NACK;
      4: return ST_DR_NACK;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // one well-formed write or random read, sometimes cut short by a fault
  task automatic run_transfer(input logic rd);
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [3:0]  plan[$];
    int          ndata;
    int          fault_at;
    int          i;
    addr = 16'($urandom);
    case ($urandom_range(0, 19))
      0:       cnt = 16'($urandom);
      1, 2:    cnt = 16'($urandom_range(7, 30));
      default: cnt = 16'($urandom_range(0, 6));
    endcase
    send_item(start_of(rd, addr, cnt));
    // start while busy
    if ($urandom_range(0, 9) == 0)
      send_item(start_of(1'($urandom), 16'($urandom), 16'($urandom)));
    plan.push_back(ST_START);
    plan.push_back(ST_SLAW_ACK);
    plan.push_back(ST_DW_ACK);
    ndata = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
    if (rd) begin
      plan.push_back(ST_DW_ACK);
      plan.push_back(ST_REP_START);
      plan.push_back(ST_SLAR_ACK);
      for (i = 1; i < ndata; i++) plan.push_back(ST_DR_ACK);
      if (cnt <= MAX_BURST) plan.push_back(ST_DR_NACK);
    end else begin
      for (i = 0; i < ndata; i++) plan.push_back(ST_DW_ACK);
      if (cnt <= MAX_BURST) plan.push_back(ST_DW_ACK);
    end
    // long transfers always end in a fault after the burst
    if (cnt > MAX_BURST) fault_at = plan.size();
    else if ($urandom_range(0, 3) == 0) fault_at = $urandom_range(0, plan.size() - 1);
    else fault_at = -1;
    for (i = 0; i < plan.size() && i != fault_at; i++) send_event(plan[i]);
    if (fault_at >= 0) send_event(pick_fault());
    // leave the block idle for the next transfer
    if (sq_phase != PH_IDLE) send_event(ST_LOST);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    // events while idle, noinfo and an unused code
    send_item(event_of(ST_DW_ACK));
    send_item(event_of(ST_NOINFO));
    send_item(event_of(4'd15));
    // zero-byte write at the top address, reset device address
    send_item(start_of(OP_WRITE, 16'hFFFF, 16'h0000));
    send_item(start_of(OP_READ, 16'h1234, 16'h0005));   // start while busy
    send_item(event_of(4'd12));
    send_item(event_of(ST_START));
    send_item(event_of(ST_NOINFO));
    send_item(event_of(ST_DW_ACK));                      // unexpected phase
    send_item(event_of(ST_SLAW_ACK));
    send_item(event_of(ST_DW_ACK));
    send_item(event_of(ST_DW_ACK));                      // stop follows address low
    // read of zero bytes: its single byte gets a nack
    send_item(start_of(OP_READ, 16'h0000, 16'h0000));
    send_item(event_of(ST_START));
    send_item(event_of(ST_SLAW_ACK));
    send_item(event_of(ST_DW_ACK));
    send_item(event_of(ST_DW_ACK));
    send_item(event_of(ST_REP_START));
    send_item(event_of(ST_SLAR_ACK));
    send_item(event_of(ST_DR_NACK));
    // lost arbitration ends quietly
    send_item(start_of(OP_WRITE, 16'h00FF, 16'h0001));
    send_item(event_of(ST_LOST));
    // largest count, then a data nack
    send_item(start_of(OP_WRITE, 16'hFF00, 16'hFFFF));
    send_item(event_of(ST_DW_NACK));
  endtask

  task automatic test_device_address();
    write_device_address(8'd0);
    run_transfer(OP_READ);
    run_transfer(OP_WRITE);
    write_device_address(8'd254);
    run_transfer(OP_READ);
    run_transfer(OP_WRITE);
    write_device_address(8'($urandom_range(0, 254)));
    run_transfer(OP_READ);
  endtask

  task automatic test_back_pressure();
    settle_idle();
    stall_req++;
    repeat (4) run_transfer(1'($urandom_range(0, 1)));
    settle_idle();
  endtask

  task automatic test_no_idle();
    int stop_at;
    idle_en = 1'b0;
    stop_at = items_sent + 250;
    while (items_sent < stop_at) run_transfer(1'($urandom_range(0, 1)));
    idle_en = 1'b1;
  endtask

  task automatic test_random(input int n);
    int stop_at;
    int last_cfg;
    int pick;
    stop_at  = items_sent + n;
    last_cfg = items_sent;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) run_transfer(OP_WRITE);
      else if (pick < 90) run_transfer(OP_READ);
      else repeat ($urandom_range(1, 3)) send_item(random_item());
      if (items_sent - last_cfg > 300) begin
        write_device_address(8'($urandom_range(0, 254)));
        last_cfg = items_sent;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = 1'b0;
    in_operation   = 1'b0;
    in_mem_address = '0;
    in_byte_count  = '0;
    in_bus_status  = '0;
    in_rx_byte     = '0;
    in_tx_byte     = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    sq_phase       = PH_IDLE;
    sq_read        = 1'b0;
    sq_addr        = '0;
    sq_left        = '0;
    sq_status      = RS_OK;
    sq_dev         = DEV_ADDR_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_device_address();
    test_back_pressure();
    test_no_idle();
    test_random(1300);

    // drain, then give any stray result time to show up
    settle_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
